>>> rtl/mct_pkg.sv
// Shared types and constants for the multiview contingency tracker.
package mct_pkg;

  localparam int ViewW = 2;
  localparam int ObsW = 10;
  localparam int ClusterW = 6;
  localparam int CellW = 11;
  localparam int CountW = 20;
  localparam int OutW = 19;

  localparam logic CfgViews = 1'b0;
  localparam logic CfgObs = 1'b1;

  localparam logic ModeLoad = 1'b0;
  localparam logic ModeMove = 1'b1;

  typedef struct packed {
    logic                mode;
    logic [ViewW-1:0]    view;
    logic [ObsW-1:0]     observation;
    logic [ClusterW-1:0] old_cluster;
    logic [ClusterW-1:0] new_cluster;
    logic                final_load;
  } in_item_t;

  typedef struct packed {
    logic [ViewW-1:0] other_view;
    logic [OutW-1:0]  marginal_pairs;
    logic [OutW-1:0]  joint_pairs;
    logic             status;
    logic             last_result;
  } out_item_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MV_SIZE_RD,
    ST_MV_SIZE_WAIT,
    ST_MV_SIZE_WR,
    ST_MV_LBL_RD,
    ST_MV_LBL_WAIT,
    ST_MV_CELL_RD,
    ST_MV_CELL_WAIT,
    ST_MV_CELL_WR,
    ST_MV_LBL_WR,
    ST_RB_SCLR,
    ST_RB_SRD,
    ST_RB_SWAIT,
    ST_RB_SWR,
    ST_RB_JCLR,
    ST_RB_JRD,
    ST_RB_JWAIT,
    ST_RB_JCELL,
    ST_RB_JWR,
    ST_REPORT
  } state_t;

endpackage

>>> rtl/mct_ram.sv
// Generic single-port synchronous RAM with registered read.
module mct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> rtl/multiview_contingency_tracker_unit.sv
// Top level of the multiview contingency tracker: control sequencer and state memories.
//
//  channel | signals                     | direction
//  in      | in_valid, in_ready, in_data | transaction in
//  out     | out_valid, out_ready, out_data | result transaction out
//  cfg     | cfg_we, cfg_index, cfg_data | register write
//
// After reset a clearing pass over every address up to the joint table memory depth zeroes all memories;
// no input transaction is taken meanwhile.
// A move updates the old and new cluster sizes, then per other view the old and new joint cells,
// then writes the label and reports; the single memory port of each store sets this pacing.
// A final load clears the view's sizes, walks the observations in use to rebuild them, then
// per other view clears its joint table and walks the observations again to rebuild it.
// Stalls on out hold the sequencer in the report state.
module multiview_contingency_tracker_unit
  import mct_pkg::*;
#(
  parameter int MAX_VIEWS = 4,
  parameter int MAX_OBSERVATIONS = 1024,
  parameter int MAX_CLUSTERS = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_data,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [10:0] cfg_data
);

  localparam int VW = (MAX_VIEWS > 1) ? $clog2(MAX_VIEWS) : 1;
  localparam int OW = $clog2(MAX_OBSERVATIONS);
  localparam int KW = $clog2(MAX_CLUSTERS);
  localparam int NPAIR = MAX_VIEWS * (MAX_VIEWS - 1) / 2 + 1;
  localparam int PW = $clog2(NPAIR);
  localparam int LDEPTH = MAX_VIEWS * MAX_OBSERVATIONS;
  localparam int SDEPTH = MAX_VIEWS * MAX_CLUSTERS;
  localparam int JDEPTH = NPAIR * MAX_CLUSTERS * MAX_CLUSTERS;
  localparam int LAW = $clog2(LDEPTH);
  localparam int SAW = $clog2(SDEPTH);
  localparam int JAW = $clog2(JDEPTH);
  localparam int CLRW = (LAW > JAW) ? LAW : JAW;
  localparam int CLRN = (LDEPTH > JDEPTH) ? LDEPTH : JDEPTH;
  localparam int NVW = $clog2(MAX_VIEWS + 1);
  localparam int NOW = $clog2(MAX_OBSERVATIONS + 1);

  state_t state, state_next;

  logic [2:0]  views_in_use;
  logic [10:0] observations_in_use;
  logic [NVW-1:0] nv;
  logic [NOW-1:0] nobs;

  in_item_t item;
  logic [VW-1:0] v;
  logic [KW-1:0] ko, kn;
  logic [OW-1:0] obs;
  logic status;

  logic [CountW-1:0] vpc [MAX_VIEWS];
  logic [CountW-1:0] jpt [NPAIR];

  logic [CLRW:0] clr_cnt;
  logic [NOW-1:0] idx;
  logic [VW:0] u;
  logic [2*KW:0] jclr;
  logic phase;
  logic [CellW-1:0] so;
  logic [KW-1:0] lbl_v;
  logic [KW-1:0] lbl_u;
  logic [CellW-1:0] cell_o;
  logic last_u;

  // memories
  logic l_we, s_we, j_we;
  logic [LAW-1:0] l_addr;
  logic [SAW-1:0] s_addr;
  logic [JAW-1:0] j_addr;
  logic [KW-1:0] l_wdata, l_rdata;
  logic [CellW-1:0] s_wdata, s_rdata, j_wdata, j_rdata;

  mct_ram #(.WIDTH(KW), .DEPTH(LDEPTH)) u_labels (
    .clk(clk), .we(l_we), .addr(l_addr), .wdata(l_wdata), .rdata(l_rdata));
  mct_ram #(.WIDTH(CellW), .DEPTH(SDEPTH)) u_sizes (
    .clk(clk), .we(s_we), .addr(s_addr), .wdata(s_wdata), .rdata(s_rdata));
  mct_ram #(.WIDTH(CellW), .DEPTH(JDEPTH)) u_joint (
    .clk(clk), .we(j_we), .addr(j_addr), .wdata(j_wdata), .rdata(j_rdata));

  always_comb begin
    if (views_in_use == 3'd0) begin
      nv = NVW'(1);
    end else if (32'(views_in_use) > MAX_VIEWS) begin
      nv = NVW'(MAX_VIEWS);
    end else begin
      nv = NVW'(views_in_use);
    end
    if (32'(observations_in_use) > MAX_OBSERVATIONS) begin
      nobs = NOW'(MAX_OBSERVATIONS);
    end else begin
      nobs = NOW'(observations_in_use);
    end
  end

  assign v = VW'(item.view);
  assign obs = OW'(item.observation);
  assign ko = KW'(item.old_cluster);
  assign kn = KW'(item.new_cluster);

  // incoming transaction checks
  logic in_use, ld_keep, mv_reject;
  assign in_use = 32'(in_data.view) < 32'(nv);
  assign ld_keep = 32'(in_data.observation) < MAX_OBSERVATIONS;
  assign mv_reject = (32'(in_data.observation) >= 32'(nobs))
                     || (32'(in_data.old_cluster) >= MAX_CLUSTERS)
                     || (32'(in_data.new_cluster) >= MAX_CLUSTERS);

  // pair index for v and u; cell address orders clusters by lower view first
  function automatic logic [PW-1:0] pair_idx(input logic [VW:0] a, input logic [VW:0] b);
    logic [VW:0] lo, hi;
    logic [31:0] r;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    r = (32'(lo) * (32'(2 * MAX_VIEWS) - 32'(lo) - 32'd1)) / 32'd2 + 32'(hi) - 32'(lo) - 32'd1;
    return PW'(r);
  endfunction

  logic [PW-1:0] pidx;
  logic [VW:0] vx;
  assign vx = {1'b0, v};
  assign pidx = pair_idx(vx, u);

  function automatic logic [JAW-1:0] cell_addr(input logic [PW-1:0] p, input logic vlow,
                                                input logic [KW-1:0] kv,
                                                input logic [KW-1:0] ku);
    logic [KW-1:0] r, c;
    r = vlow ? kv : ku;
    c = vlow ? ku : kv;
    return JAW'({p, r, c});
  endfunction

  logic vlow;
  assign vlow = vx < u;

  logic u_skip, u_done;
  assign u_skip = (u == vx);
  assign u_done = (u >= (VW+1)'(nv));

  logic [CountW-1:0] out_marg, out_joint;
  logic [CountW-1:0] marg_cur;
  assign marg_cur = vpc[v];

  always_comb begin
    state_next = state;
    l_we = 1'b0;
    s_we = 1'b0;
    j_we = 1'b0;
    l_addr = LAW'({v, obs});
    s_addr = SAW'({v, ko});
    j_addr = cell_addr(pidx, vlow, ko, lbl_u);
    l_wdata = kn;
    s_wdata = '0;
    j_wdata = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    out_marg = marg_cur;
    out_joint = '0;
    case (state)
      ST_CLEAR: begin
        l_we = (clr_cnt < (CLRW+1)'(LDEPTH));
        s_we = (clr_cnt < (CLRW+1)'(SDEPTH));
        j_we = (clr_cnt < (CLRW+1)'(JDEPTH));
        l_addr = LAW'(clr_cnt);
        s_addr = SAW'(clr_cnt);
        j_addr = JAW'(clr_cnt);
        l_wdata = '0;
        if (clr_cnt == (CLRW+1)'(CLRN - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && in_use) begin
          if (in_data.mode == ModeLoad) begin
            // store the label right away
            l_we = ld_keep;
            l_addr = LAW'({VW'(in_data.view), OW'(in_data.observation)});
            l_wdata = KW'(in_data.new_cluster);
            if (in_data.final_load) state_next = ST_RB_SCLR;
          end else if (mv_reject) begin
            state_next = ST_REPORT;
          end else begin
            state_next = ST_MV_SIZE_RD;
          end
        end
      end
      ST_MV_SIZE_RD: begin
        s_addr = SAW'({v, ko});
        state_next = ST_MV_SIZE_WAIT;
      end
      ST_MV_SIZE_WAIT: begin
        // phase 0 reads the old size, phase 1 the new size
        s_addr = phase ? SAW'({v, kn}) : SAW'({v, ko});
        state_next = ST_MV_SIZE_WR;
      end
      ST_MV_SIZE_WR: begin
        if (!phase) begin
          if (s_rdata == '0 || ko == kn) begin
            state_next = ST_REPORT;
          end else begin
            s_we = 1'b1;
            s_addr = SAW'({v, ko});
            s_wdata = s_rdata - CellW'(1);
            state_next = ST_MV_SIZE_RD;
          end
        end else begin
          s_we = 1'b1;
          s_addr = SAW'({v, kn});
          s_wdata = s_rdata + CellW'(1);
          state_next = ST_MV_LBL_RD;
        end
      end
      ST_MV_LBL_RD: begin
        if (u_done) begin
          state_next = ST_MV_LBL_WR;
        end else if (u_skip) begin
          state_next = ST_MV_LBL_RD;
        end else begin
          l_addr = LAW'({u[VW-1:0], obs});
          state_next = ST_MV_LBL_WAIT;
        end
      end
      ST_MV_LBL_WAIT: begin
        state_next = ST_MV_CELL_RD;
      end
      ST_MV_CELL_RD: begin
        j_addr = cell_addr(pidx, vlow, phase ? kn : ko, lbl_u);
        state_next = ST_MV_CELL_WAIT;
      end
      ST_MV_CELL_WAIT: begin
        j_addr = cell_addr(pidx, vlow, phase ? kn : ko, lbl_u);
        state_next = ST_MV_CELL_WR;
      end
      ST_MV_CELL_WR: begin
        j_we = 1'b1;
        j_addr = cell_addr(pidx, vlow, phase ? kn : ko, lbl_u);
        j_wdata = phase ? j_rdata + CellW'(1) : j_rdata - CellW'(1);
        state_next = phase ? ST_MV_LBL_RD : ST_MV_CELL_RD;
      end
      ST_MV_LBL_WR: begin
        l_we = 1'b1;
        l_addr = LAW'({v, obs});
        l_wdata = kn;
        state_next = ST_REPORT;
      end
      ST_RB_SCLR: begin
        s_we = 1'b1;
        s_addr = SAW'({v, jclr[KW-1:0]});
        if (jclr[KW-1:0] == KW'(MAX_CLUSTERS - 1)) state_next = ST_RB_SRD;
      end
      ST_RB_SRD: begin
        if (idx >= nobs) begin
          state_next = ST_RB_JCLR;
        end else begin
          l_addr = LAW'({v, idx[OW-1:0]});
          state_next = ST_RB_SWAIT;
        end
      end
      ST_RB_SWAIT: begin
        s_addr = SAW'({v, l_rdata});
        state_next = ST_RB_SWR;
      end
      ST_RB_SWR: begin
        if (phase) begin
          s_we = 1'b1;
          s_addr = SAW'({v, lbl_v});
          s_wdata = s_rdata + CellW'(1);
          state_next = ST_RB_SRD;
        end else begin
          s_addr = SAW'({v, lbl_v});
        end
      end
      ST_RB_JCLR: begin
        if (u_done) begin
          state_next = ST_REPORT;
        end else if (!u_skip) begin
          j_we = 1'b1;
          j_addr = JAW'({pidx, jclr[2*KW-1:0]});
          if (jclr[2*KW-1:0] == (2*KW)'(MAX_CLUSTERS * MAX_CLUSTERS - 1)) begin
            state_next = ST_RB_JRD;
          end
        end
      end
      ST_RB_JRD: begin
        if (idx >= nobs) begin
          state_next = ST_RB_JCLR;
        end else begin
          l_addr = phase ? LAW'({u[VW-1:0], idx[OW-1:0]}) : LAW'({v, idx[OW-1:0]});
          state_next = ST_RB_JWAIT;
        end
      end
      ST_RB_JWAIT: begin
        state_next = phase ? ST_RB_JCELL : ST_RB_JRD;
      end
      ST_RB_JCELL: begin
        j_addr = cell_addr(pidx, vlow, lbl_v, lbl_u);
        state_next = ST_RB_JWR;
      end
      ST_RB_JWR: begin
        if (phase) begin
          j_we = 1'b1;
          j_addr = cell_addr(pidx, vlow, lbl_v, lbl_u);
          j_wdata = j_rdata + CellW'(1);
          state_next = ST_RB_JRD;
        end else begin
          j_addr = cell_addr(pidx, vlow, lbl_v, lbl_u);
        end
      end
      ST_REPORT: begin
        if (nv == NVW'(1)) begin
          out_valid = 1'b1;
          out_joint = '0;
          if (out_ready) state_next = ST_IDLE;
        end else if (u_done) begin
          state_next = ST_IDLE;
        end else if (!u_skip) begin
          out_valid = 1'b1;
          out_joint = jpt[pidx];
          if (out_ready && last_u) state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // last result: no further non-skipped view after u
  always_comb begin
    if (nv == NVW'(1)) begin
      last_u = 1'b1;
    end else if (u + (VW+1)'(1) == (VW+1)'(nv)) begin
      last_u = 1'b1;
    end else if (u + (VW+1)'(2) == (VW+1)'(nv) && u + (VW+1)'(1) == vx) begin
      last_u = 1'b1;
    end else begin
      last_u = 1'b0;
    end
  end

  always_comb begin
    out_data.other_view = (nv == NVW'(1)) ? ViewW'(0) : ViewW'(u);
    out_data.marginal_pairs = out_marg[OutW-1:0];
    out_data.joint_pairs = out_joint[OutW-1:0];
    out_data.status = status;
    out_data.last_result = last_u;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      views_in_use <= 3'd1;
      observations_in_use <= '0;
      clr_cnt <= '0;
      for (int i = 0; i < MAX_VIEWS; i++) vpc[i] <= '0;
      for (int i = 0; i < NPAIR; i++) jpt[i] <= '0;
      u <= '0;
      idx <= '0;
      jclr <= '0;
      phase <= 1'b0;
      status <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        if (cfg_index == CfgViews) views_in_use <= cfg_data[2:0];
        else observations_in_use <= cfg_data;
      end
      case (state)
        ST_CLEAR: clr_cnt <= clr_cnt + (CLRW+1)'(1);
        ST_IDLE: begin
          if (in_valid) begin
            item <= in_data;
            status <= (in_data.mode == ModeMove) && mv_reject;
            u <= '0;
            idx <= '0;
            jclr <= '0;
            phase <= 1'b0;
          end
        end
        ST_MV_SIZE_WAIT: ;
        ST_MV_SIZE_WR: begin
          if (!phase) begin
            if (s_rdata == '0) begin
              status <= 1'b1;
            end else if (ko != kn) begin
              so <= s_rdata;
              phase <= 1'b1;
            end
          end else begin
            // s_rdata is size of new cluster
            vpc[v] <= vpc[v] + CountW'(s_rdata) - CountW'(so) + CountW'(1);
            phase <= 1'b0;
          end
        end
        ST_MV_LBL_RD: begin
          if (!u_done && u_skip) u <= u + (VW+1)'(1);
        end
        ST_MV_LBL_WAIT: lbl_u <= l_rdata;
        ST_MV_CELL_WR: begin
          if (!phase) begin
            cell_o <= j_rdata;
            phase <= 1'b1;
          end else begin
            jpt[pidx] <= jpt[pidx] + CountW'(j_rdata) - CountW'(cell_o) + CountW'(1);
            phase <= 1'b0;
            u <= u + (VW+1)'(1);
          end
        end
        ST_MV_LBL_WR: u <= '0;
        ST_RB_SCLR: begin
          vpc[v] <= '0;
          if (jclr[KW-1:0] == KW'(MAX_CLUSTERS - 1)) jclr <= '0;
          else jclr <= jclr + (2*KW+1)'(1);
        end
        ST_RB_SWAIT: begin
          lbl_v <= l_rdata;
          phase <= 1'b0;
        end
        ST_RB_SRD: begin
          if (idx >= nobs) begin
            idx <= '0;
            u <= '0;
            jclr <= '0;
          end
        end
        ST_RB_SWR: begin
          if (!phase) begin
            phase <= 1'b1;
          end else begin
            vpc[v] <= vpc[v] + CountW'(s_rdata);
            phase <= 1'b0;
            idx <= idx + NOW'(1);
          end
        end
        ST_RB_JCLR: begin
          if (!u_done) begin
            if (u_skip) begin
              u <= u + (VW+1)'(1);
            end else begin
              jclr <= jclr + (2*KW+1)'(1);
              jpt[pidx] <= '0;
              idx <= '0;
              phase <= 1'b0;
            end
          end else begin
            u <= '0;
          end
        end
        ST_RB_JRD: begin
          if (idx >= nobs) begin
            u <= u + (VW+1)'(1);
            jclr <= '0;
          end
        end
        ST_RB_JWAIT: begin
          if (!phase) lbl_v <= l_rdata;
          else lbl_u <= l_rdata;
          phase <= ~phase;
        end
        ST_RB_JWR: begin
          if (!phase) begin
            phase <= 1'b1;
          end else begin
            jpt[pidx] <= jpt[pidx] + CountW'(j_rdata);
            phase <= 1'b0;
            idx <= idx + NOW'(1);
          end
        end
        ST_REPORT: begin
          if (nv != NVW'(1)) begin
            if (u_skip && !u_done) u <= u + (VW+1)'(1);
            else if (!u_done && out_ready) u <= u + (VW+1)'(1);
          end
        end
        default: ;
      endcase
    end
  end

endmodule
